[hw/rtl/lljd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lljd_pkg
// Shared widths, defaults and controller states for the job dispatcher.
// ----------------------------------------------------------------------------
package lljd_pkg;

    localparam int MAX_MACHINES_DEF = 128;
    localparam int LOAD_W           = 32;
    localparam int JOB_W            = 15;
    localparam int MID_W            = 7;
    localparam int CFG_W            = 8;
    localparam int S_DATA_W         = 16;
    localparam int M_DATA_W         = 72;

    localparam logic [CFG_W-1:0] MACHINE_COUNT_RST = 8'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE
    } lljd_state_t;

endpackage

[hw/rtl/lljd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lljd_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lljd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hw/rtl/least_loaded_job_dispatcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_job_dispatcher
// Greedy list scheduling: each job goes to the least loaded active machine.
// The load scan reads one machine load per cycle from the RAM for the active
//   machines, then the new load is written back and registered as the result.
// A first_job beat sweeps all MAX_MACHINES entries to zero, then takes machine 0.
// One job in flight at a time; the output register holds a result while the
//   next job is taken and scanned.
// After reset the load RAM is cleared, all MAX_MACHINES entries, with s_tready low.
// ----------------------------------------------------------------------------
module least_loaded_job_dispatcher #(
    parameter int MAX_MACHINES = lljd_pkg::MAX_MACHINES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lljd_pkg::S_DATA_W-1:0]  s_tdata,   // [14:0] job_time, [15] zero
    input  logic                           s_tuser,   // [0] first_job
    input  logic                           s_tlast,   // last_job
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lljd_pkg::M_DATA_W-1:0]  m_tdata,   // [6:0] chosen_machine,
                                                      // [38:7] finish_time,
                                                      // [70:39] makespan, [71] zero
    output logic                           m_tlast,   // set_done
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lljd_pkg::CFG_W-1:0]     cfg_data   // machine_count
);

    import lljd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_MACHINES);
    localparam int CNT_W  = $clog2(MAX_MACHINES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_MACHINES - 1);

    lljd_state_t        state_reg, state_next;
    logic [CFG_W-1:0]   mcount_reg, mcount_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               rv_reg, rv_next;
    logic [ADDR_W-1:0]  ridx_reg, ridx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [JOB_W-1:0]   job_reg, job_next;
    logic               last_reg, last_next;
    logic [LOAD_W-1:0]  best_load_reg, best_load_next;
    logic [ADDR_W-1:0]  best_idx_reg, best_idx_next;
    logic [LOAD_W-1:0]  span_reg, span_next;
    logic               out_valid_reg, out_valid_next;
    logic [MID_W-1:0]   out_mach_reg, out_mach_next;
    logic [LOAD_W-1:0]  out_fin_reg, out_fin_next;
    logic [LOAD_W-1:0]  out_span_reg, out_span_next;
    logic               out_done_reg, out_done_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [LOAD_W-1:0]  ram_wdata;
    logic [LOAD_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]   active_cnt;
    logic [LOAD_W:0]    sum;
    logic [LOAD_W-1:0]  new_load;

    lljd_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (MAX_MACHINES)
    ) u_load_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // zero -> one machine, above MAX_MACHINES -> MAX_MACHINES
    always_comb
    begin
        if (mcount_reg == '0)
        begin
            active_cnt = CNT_W'(1);
        end
        else if (32'(mcount_reg) > 32'(MAX_MACHINES))
        begin
            active_cnt = CNT_W'(MAX_MACHINES);
        end
        else
        begin
            active_cnt = CNT_W'(mcount_reg);
        end
    end

    assign sum      = {1'b0, best_load_reg} + (LOAD_W + 1)'(job_reg);
    assign new_load = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];

    assign cfg_ready   = 1'b1;
    assign mcount_next = (cfg_valid) ? cfg_data : mcount_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pend_next      = pend_reg;
        iss_next       = iss_reg;
        rv_next        = rv_reg;
        ridx_next      = ridx_reg;
        cnt_next       = cnt_reg;
        job_next       = job_reg;
        last_next      = last_reg;
        best_load_next = best_load_reg;
        best_idx_next  = best_idx_reg;
        span_next      = span_reg;
        out_valid_next = out_valid_reg;
        out_mach_next  = out_mach_reg;
        out_fin_next   = out_fin_reg;
        out_span_next  = out_span_reg;
        out_done_next  = out_done_reg;
        ram_we         = 1'b0;
        ram_addr       = iss_reg[ADDR_W-1:0];
        ram_wdata      = '0;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = pend_reg ? ST_WRITE : ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    job_next       = s_tdata[JOB_W-1:0];
                    last_next      = s_tlast;
                    cnt_next       = active_cnt;
                    best_load_next = '0;
                    best_idx_next  = '0;
                    pend_next      = 1'b1;
                    iss_next       = '0;
                    rv_next        = 1'b0;
                    if (s_tuser)
                    begin
                        span_next  = '0;
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                // ties keep the lower index: strict less-than only
                if (rv_reg && ((ridx_reg == '0) || (ram_rdata < best_load_reg)))
                begin
                    best_load_next = ram_rdata;
                    best_idx_next  = ridx_reg;
                end
                if (iss_reg < cnt_reg)
                begin
                    ram_addr  = iss_reg[ADDR_W-1:0];
                    iss_next  = iss_reg + 1'b1;
                    rv_next   = 1'b1;
                    ridx_next = iss_reg[ADDR_W-1:0];
                end
                else
                begin
                    rv_next = 1'b0;
                    if (!rv_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_WRITE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    ram_we         = 1'b1;
                    ram_addr       = best_idx_reg;
                    ram_wdata      = new_load;
                    span_next      = (new_load > span_reg) ? new_load : span_reg;
                    out_valid_next = 1'b1;
                    out_mach_next  = MID_W'(best_idx_reg);
                    out_fin_next   = new_load;
                    out_span_next  = (new_load > span_reg) ? new_load : span_reg;
                    out_done_next  = last_reg;
                    pend_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mcount_reg    <= MACHINE_COUNT_RST;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            iss_reg       <= '0;
            rv_reg        <= 1'b0;
            span_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mcount_reg    <= mcount_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            iss_reg       <= iss_next;
            rv_reg        <= rv_next;
            span_reg      <= span_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg      <= ridx_next;
        cnt_reg       <= cnt_next;
        job_reg       <= job_next;
        last_reg      <= last_next;
        best_load_reg <= best_load_next;
        best_idx_reg  <= best_idx_next;
        out_mach_reg  <= out_mach_next;
        out_fin_reg   <= out_fin_next;
        out_span_reg  <= out_span_next;
        out_done_reg  <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_span_reg, out_fin_reg, out_mach_reg};
    assign m_tlast  = out_done_reg;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for least_loaded_job_dispatcher. Job beats go in on the
// slave stream and every result beat is checked against a software copy of
// the greedy list scheduler: per-machine loads, tie to the lowest index,
// saturating loads and makespan, clearing on first_job. Runs directed cases
// and random job sets under many machine counts with random stalls on both
// sides.
// ----------------------------------------------------------------------------
module testbench;
    import lljd_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = MAX_MACHINES_DEF + 8;
    localparam int PHASE_JOBS    = 70;
    localparam logic [JOB_W-1:0] JOB_MAX = '1;

    typedef struct packed {
        logic [MID_W-1:0]  machine;
        logic [LOAD_W-1:0] finish;
        logic [LOAD_W-1:0] span;
        logic              done;
    } assignment_t;

    class dispatch_checker;
        logic [LOAD_W-1:0] machine_load [MAX_MACHINES_DEF];
        logic [LOAD_W-1:0] largest_load;
        logic [CFG_W-1:0]  machine_count;
        assignment_t       expected_assignments [$];
        int                mismatch_count;
        int                checked_count;

        function new();
            foreach (machine_load[k])
                machine_load[k] = '0;
            largest_load   = '0;
            machine_count  = MACHINE_COUNT_RST;
            mismatch_count = 0;
            checked_count  = 0;
        endfunction

        function void set_machine_count(logic [CFG_W-1:0] value);
            machine_count = value;
        endfunction

        function void note_job(logic [JOB_W-1:0] job_time, logic first_job, logic last_job);
            int          active;
            int          best;
            logic [LOAD_W:0] sum;
            assignment_t a;
            active = (machine_count == 0) ? 1 : int'(machine_count);
            if (active > MAX_MACHINES_DEF)
                active = MAX_MACHINES_DEF;
            if (first_job)
            begin
                foreach (machine_load[k])
                    machine_load[k] = '0;
                largest_load = '0;
            end
            best = 0;
            for (int k = 1; k < active; k++)
                if (machine_load[k] < machine_load[best])
                    best = k;
            sum = {1'b0, machine_load[best]} + (LOAD_W + 1)'(job_time);
            machine_load[best] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
            if (machine_load[best] > largest_load)
                largest_load = machine_load[best];
            a.machine = MID_W'(best);
            a.finish  = machine_load[best];
            a.span    = largest_load;
            a.done    = last_job;
            expected_assignments.push_back(a);
        endfunction

        function void check_result(logic [MID_W-1:0] machine, logic [LOAD_W-1:0] finish,
                                   logic [LOAD_W-1:0] span, logic done);
            assignment_t want;
            if (expected_assignments.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: machine %0d finish %0d makespan %0d",
                             machine, finish, span);
                return;
            end
            want = expected_assignments.pop_front();
            checked_count++;
            if (want.machine !== machine || want.finish !== finish ||
                want.span !== span || want.done !== done)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch on result %0d: exp m%0d/%0d/%0d/%0b got m%0d/%0d/%0d/%0b",
                             checked_count, want.machine, want.finish, want.span, want.done,
                             machine, finish, span, done);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;

    dispatch_checker sb = new();
    bit idle_on = 1'b1;
    int idle_cycles = 0;
    int jobs_sent = 0;
    int sets_started = 0;
    int count_writes = 0;
    int phase_sent;
    int set_len;
    int phase_counts [10] = '{1, 2, 3, 5, 16, 128, 0, 200, 64, 0};

    least_loaded_job_dispatcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [JOB_W-1:0] pick_job_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return JOB_MAX;
            2, 3:    return JOB_W'($urandom_range(1, 15));
            default: return JOB_W'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic int pick_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 6);
        return 0;
    endfunction

    // called and returns at a falling edge
    task automatic send_job(logic [JOB_W-1:0] job_time, logic first_job, logic last_job,
                            int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, job_time};
        s_tuser  <= first_job;
        s_tlast  <= last_job;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_job(job_time, first_job, last_job);
        jobs_sent++;
        if (first_job)
            sets_started++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic run_set(int n, bit clean);
        logic first_job;
        logic last_job;
        for (int i = 0; i < n; i++)
        begin
            first_job = clean ? (i == 0) : ($urandom_range(0, 7) == 0);
            last_job  = clean ? (i == n - 1) : ($urandom_range(0, 7) == 0);
            send_job(pick_job_time(), first_job, last_job, pick_gap());
        end
    endtask

    task automatic settle_jobs();
        s_tvalid <= 1'b0;
        while (sb.expected_assignments.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_machine_count(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_machine_count(value);
        count_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall bursts
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[6:0], m_tdata[38:7], m_tdata[70:39], m_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.expected_assignments.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset count of two, loads accumulate from reset, ties go low
        send_job(15'd5, 1'b0, 1'b0, 0);
        send_job(15'd5, 1'b0, 1'b0, 1);
        send_job(15'd3, 1'b0, 1'b0, 0);
        send_job(15'd0, 1'b0, 1'b0, 2);
        send_job(JOB_MAX, 1'b0, 1'b1, 0);
        send_job(15'd7, 1'b1, 1'b0, 0);
        send_job(15'd7, 1'b0, 1'b1, 0);
        settle_jobs();

        // zero count acts as one machine
        write_machine_count(8'd0);
        send_job(15'd10, 1'b1, 1'b0, 0);
        send_job(15'd20, 1'b0, 1'b1, 0);
        settle_jobs();

        // count above the machine limit clamps
        write_machine_count(8'd255);
        send_job(15'd1, 1'b1, 1'b0, 0);
        send_job(JOB_MAX, 1'b0, 1'b0, 0);
        send_job(15'd2, 1'b0, 1'b1, 0);
        settle_jobs();

        // shrink the count mid-set: machine 7 keeps the makespan
        write_machine_count(8'd8);
        send_job(15'd10, 1'b1, 1'b0, 0);
        for (int i = 0; i < 6; i++)
            send_job(15'd10, 1'b0, 1'b0, pick_gap());
        send_job(JOB_MAX, 1'b0, 1'b0, 0);
        settle_jobs();
        write_machine_count(8'd3);
        send_job(15'd5, 1'b0, 1'b0, 0);
        send_job(15'd5, 1'b0, 1'b0, 3);
        send_job(15'd5, 1'b0, 1'b1, 0);

        for (int p = 0; p < 10; p++)
        begin
            settle_jobs();
            idle_on = (p % 4 != 3) && (p != 9);
            write_machine_count((p == 9) ? CFG_W'($urandom_range(0, 255))
                                         : CFG_W'(phase_counts[p]));
            phase_sent = 0;
            while (phase_sent < PHASE_JOBS)
            begin
                set_len = $urandom_range(1, 12);
                run_set(set_len, $urandom_range(0, 4) != 0);
                phase_sent += set_len;
            end
        end

        settle_jobs();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d jobs in %0d cleared sets over %0d machine-count writes (0 to 255).",
                 jobs_sent, sets_started, count_writes);
        $display("Checked %0d results, %0d mismatches, %0d missing.",
                 sb.checked_count, sb.mismatch_count, sb.expected_assignments.size());
        if (sb.mismatch_count == 0 && sb.expected_assignments.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
